### src/lcd_draw_command_engine_assert.svh
// Assertion helpers for the draw command engine.
// Both forms sample on clk and are held off while rst_n is low.
`ifndef LCD_DRAW_COMMAND_ENGINE_ASSERT_SVH
`define LCD_DRAW_COMMAND_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCDD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lcdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdd_pkg
// Shared types, codes and tables of the draw command engine.
// ----------------------------------------------------------------------------
package lcdd_pkg;

  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 320;
  localparam int DIM_W            = 9;
  localparam int Q_DEPTH          = 4;
  localparam int RUN_W            = 17;
  localparam logic [RUN_W-1:0] RUN_MAX = 17'h1FFFF;

  localparam logic [7:0] OP_COLSET = 8'h2A;
  localparam logic [7:0] OP_ROWSET = 8'h2B;
  localparam logic [7:0] OP_MEMWR  = 8'h2C;
  localparam logic [7:0] OP_MADCTL = 8'h36;
  localparam logic [7:0] OP_INVOFF = 8'h20;
  localparam logic [7:0] OP_INVON  = 8'h21;

  localparam logic [7:0] FLAG_MY  = 8'h80;
  localparam logic [7:0] FLAG_MX  = 8'h40;
  localparam logic [7:0] FLAG_MV  = 8'h20;
  localparam logic [7:0] FLAG_BGR = 8'h08;

  typedef enum logic [2:0] {
    CMD_PIXEL  = 3'd0,
    CMD_HLINE  = 3'd1,
    CMD_VLINE  = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_ROTATE = 3'd4,
    CMD_INVERT = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_PIXEL,
    KIND_HLINE,
    KIND_VLINE,
    KIND_RECT,
    KIND_RECT_NORUN,
    KIND_ROT,
    KIND_INV
  } kind_t;

  typedef enum logic [3:0] {
    BEAT_COLSET = 4'd0,
    BEAT_X0_HI  = 4'd1,
    BEAT_X0_LO  = 4'd2,
    BEAT_X1_HI  = 4'd3,
    BEAT_X1_LO  = 4'd4,
    BEAT_ROWSET = 4'd5,
    BEAT_Y0_HI  = 4'd6,
    BEAT_Y0_LO  = 4'd7,
    BEAT_Y1_HI  = 4'd8,
    BEAT_Y1_LO  = 4'd9,
    BEAT_MEMWR  = 4'd10,
    BEAT_RUN    = 4'd11
  } beat_t;

  // One classified word handed from front to back.
  // For rotation, color holds the flag byte; for inversion, the opcode.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] ext_x;
    logic [15:0] ext_y;
    logic [15:0] color;
  } desc_t;

  typedef struct packed {
    logic                         full;
    logic                         empty;
    logic [$clog2(Q_DEPTH+1)-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic  active;
    kind_t kind;
    beat_t beat;
  } bk_status_t;

  function automatic logic [7:0] rot_flags(input logic [1:0] rot);
    logic [7:0] f;
    case (rot)
      2'd0:    f = FLAG_MX | FLAG_BGR;
      2'd1:    f = FLAG_MV | FLAG_BGR;
      2'd2:    f = FLAG_MY | FLAG_BGR;
      default: f = FLAG_MX | FLAG_MY | FLAG_MV | FLAG_BGR;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

### src/lcdd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdd_front
// Classifies and clips each accepted command and keeps the screen size.
// ----------------------------------------------------------------------------
module lcdd_front #(
  parameter int PANEL_WIDTH  = lcdd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdd_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] span_w,
  input  wire logic signed [15:0] span_h,
  input  wire logic [15:0]        color,
  input  wire logic [1:0]         rotation,
  input  wire logic               invert_on,
  output logic                    push,
  output lcdd_pkg::desc_t         push_data
);

  localparam logic [lcdd_pkg::DIM_W-1:0] PW = lcdd_pkg::DIM_W'(PANEL_WIDTH);
  localparam logic [lcdd_pkg::DIM_W-1:0] PH = lcdd_pkg::DIM_W'(PANEL_HEIGHT);

  logic [lcdd_pkg::DIM_W-1:0] scr_w_r, scr_w_nxt;
  logic [lcdd_pkg::DIM_W-1:0] scr_h_r, scr_h_nxt;

  logic signed [17:0] xs, ys, ws, hs, sw, sh, x_end, y_end, x_room, y_room;
  logic signed [15:0] w_cut, h_cut;
  logic               x_in, y_in, pix_ok;
  logic               keep;

  assign xs     = {{2{pos_x[15]}}, pos_x};
  assign ys     = {{2{pos_y[15]}}, pos_y};
  assign ws     = {{2{span_w[15]}}, span_w};
  assign hs     = {{2{span_h[15]}}, span_h};
  assign sw     = {{(18-lcdd_pkg::DIM_W){1'b0}}, scr_w_r};
  assign sh     = {{(18-lcdd_pkg::DIM_W){1'b0}}, scr_h_r};
  assign x_in   = xs < sw;
  assign y_in   = ys < sh;
  assign pix_ok = (xs >= 18'sd0) && x_in && (ys >= 18'sd0) && y_in;
  assign x_end  = xs + ws - 18'sd1;
  assign y_end  = ys + hs - 18'sd1;
  assign x_room = sw - xs;
  assign y_room = sh - ys;
  assign w_cut  = (x_end >= sw) ? x_room[15:0] : span_w;
  assign h_cut  = (y_end >= sh) ? y_room[15:0] : span_h;

  always_comb begin
    keep              = 1'b0;
    push_data.kind    = lcdd_pkg::KIND_PIXEL;
    push_data.x0      = pos_x;
    push_data.y0      = pos_y;
    push_data.ext_x   = 16'd2;
    push_data.ext_y   = 16'd2;
    push_data.color   = color;
    scr_w_nxt         = scr_w_r;
    scr_h_nxt         = scr_h_r;
    case (cmd)
      lcdd_pkg::CMD_PIXEL: begin
        keep = pix_ok;
      end
      lcdd_pkg::CMD_HLINE: begin
        if (x_in && y_in && span_w >= 16'sd1) begin
          if (w_cut < 16'sd2) begin
            keep = pix_ok;
          end else begin
            keep            = 1'b1;
            push_data.kind  = lcdd_pkg::KIND_HLINE;
            push_data.ext_x = w_cut;
            push_data.ext_y = 16'd1;
          end
        end
      end
      lcdd_pkg::CMD_VLINE: begin
        if (x_in && y_in && span_h >= 16'sd1) begin
          if (h_cut < 16'sd2) begin
            keep = pix_ok;
          end else begin
            keep            = 1'b1;
            push_data.kind  = lcdd_pkg::KIND_VLINE;
            push_data.ext_x = 16'd1;
            push_data.ext_y = h_cut;
          end
        end
      end
      lcdd_pkg::CMD_FILL: begin
        if (x_in && y_in && span_w >= 16'sd1 && span_h >= 16'sd1) begin
          if (w_cut == 16'sd1 || h_cut == 16'sd1) begin
            keep = pix_ok;
          end else begin
            keep            = 1'b1;
            push_data.kind  = (w_cut > 16'sd0 && h_cut > 16'sd0) ?
                              lcdd_pkg::KIND_RECT : lcdd_pkg::KIND_RECT_NORUN;
            push_data.ext_x = w_cut;
            push_data.ext_y = h_cut;
          end
        end
      end
      lcdd_pkg::CMD_ROTATE: begin
        keep            = 1'b1;
        push_data.kind  = lcdd_pkg::KIND_ROT;
        push_data.color = {8'h00, lcdd_pkg::rot_flags(rotation)};
        scr_w_nxt       = rotation[0] ? PH : PW;
        scr_h_nxt       = rotation[0] ? PW : PH;
      end
      lcdd_pkg::CMD_INVERT: begin
        keep            = 1'b1;
        push_data.kind  = lcdd_pkg::KIND_INV;
        push_data.color = {8'h00, invert_on ? lcdd_pkg::OP_INVON : lcdd_pkg::OP_INVOFF};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= PW;
      scr_h_r <= PH;
    end else if (accept) begin
      scr_w_r <= scr_w_nxt;
      scr_h_r <= scr_h_nxt;
    end
  end

endmodule
`default_nettype wire

### src/lcdd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdd_queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module lcdd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lcdd_pkg::desc_t  push_data,
  input  wire logic             pop,
  output lcdd_pkg::desc_t       head,
  output lcdd_pkg::q_status_t   status
);

  localparam int AW = $clog2(lcdd_pkg::Q_DEPTH);
  localparam int CW = $clog2(lcdd_pkg::Q_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(lcdd_pkg::Q_DEPTH - 1);

  lcdd_pkg::desc_t slot_r [lcdd_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(lcdd_pkg::Q_DEPTH));

endmodule
`default_nettype wire

### src/lcdd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdd_back
// Sequences one bus word per cycle, while the output is not stalled, for the word at the head of the queue.
// ----------------------------------------------------------------------------
module lcdd_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lcdd_pkg::desc_t                head,
  input  wire lcdd_pkg::q_status_t            q_status,
  output logic                                pop,
  output lcdd_pkg::bk_status_t                status,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_is_command,
  output logic [15:0]                         out_bus_value,
  output logic [lcdd_pkg::RUN_W-1:0]          out_repeat_count,
  output logic                                out_last
);

  lcdd_pkg::desc_t d_r;
  lcdd_pkg::beat_t beat_r, beat_nxt;
  logic            active_r, active_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     prod_r;

  logic [15:0]                x1, y1;
  logic [lcdd_pkg::RUN_W-1:0] run_cnt;
  logic                       b_cmd, b_last;
  logic [15:0]                b_val;
  logic [lcdd_pkg::RUN_W-1:0] b_rep;
  logic                       adv, load;

  assign x1 = d_r.x0 + d_r.ext_x - 16'd1;
  assign y1 = d_r.y0 + d_r.ext_y - 16'd1;
  assign run_cnt = (d_r.kind == lcdd_pkg::KIND_PIXEL) ? lcdd_pkg::RUN_W'(1) :
                   (prod_r > {15'd0, lcdd_pkg::RUN_MAX}) ? lcdd_pkg::RUN_MAX :
                   prod_r[lcdd_pkg::RUN_W-1:0];

  always_comb begin
    b_cmd  = 1'b0;
    b_val  = 16'd0;
    b_rep  = lcdd_pkg::RUN_W'(1);
    b_last = 1'b0;
    case (d_r.kind)
      lcdd_pkg::KIND_ROT: begin
        b_cmd  = (beat_r == lcdd_pkg::BEAT_COLSET);
        b_val  = b_cmd ? {8'h00, lcdd_pkg::OP_MADCTL} : d_r.color;
        b_last = !b_cmd;
      end
      lcdd_pkg::KIND_INV: begin
        b_cmd  = 1'b1;
        b_val  = d_r.color;
        b_last = 1'b1;
      end
      default: begin
        unique case (beat_r)
          lcdd_pkg::BEAT_COLSET: begin
            b_cmd = 1'b1;
            b_val = {8'h00, lcdd_pkg::OP_COLSET};
          end
          lcdd_pkg::BEAT_X0_HI:  b_val = {8'h00, d_r.x0[15:8]};
          lcdd_pkg::BEAT_X0_LO:  b_val = {8'h00, d_r.x0[7:0]};
          lcdd_pkg::BEAT_X1_HI:  b_val = {8'h00, x1[15:8]};
          lcdd_pkg::BEAT_X1_LO:  b_val = {8'h00, x1[7:0]};
          lcdd_pkg::BEAT_ROWSET: begin
            b_cmd = 1'b1;
            b_val = {8'h00, lcdd_pkg::OP_ROWSET};
          end
          lcdd_pkg::BEAT_Y0_HI:  b_val = {8'h00, d_r.y0[15:8]};
          lcdd_pkg::BEAT_Y0_LO:  b_val = {8'h00, d_r.y0[7:0]};
          lcdd_pkg::BEAT_Y1_HI:  b_val = {8'h00, y1[15:8]};
          lcdd_pkg::BEAT_Y1_LO:  b_val = {8'h00, y1[7:0]};
          lcdd_pkg::BEAT_MEMWR: begin
            b_cmd  = 1'b1;
            b_val  = {8'h00, lcdd_pkg::OP_MEMWR};
            b_last = (d_r.kind == lcdd_pkg::KIND_RECT_NORUN);
          end
          lcdd_pkg::BEAT_RUN: begin
            b_val  = d_r.color;
            b_rep  = run_cnt;
            b_last = 1'b1;
          end
          default: b_val = 16'd0;
        endcase
      end
    endcase
  end

  assign adv  = !out_valid_r || !out_stall;
  assign load = !q_status.empty && (!active_r || (adv && b_last));
  assign pop  = load;

  always_comb begin
    active_nxt    = active_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = active_r;
      if (active_r) begin
        beat_nxt = lcdd_pkg::beat_t'(beat_r + 4'd1);
        if (b_last) begin
          active_nxt = 1'b0;
        end
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      beat_nxt   = lcdd_pkg::BEAT_COLSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      beat_r      <= lcdd_pkg::BEAT_COLSET;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r <= head;
    end
    prod_r <= 32'(d_r.ext_x) * 32'(d_r.ext_y);
    if (adv && active_r) begin
      out_is_command   <= b_cmd;
      out_bus_value    <= b_val;
      out_repeat_count <= b_rep;
      out_last         <= b_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign status.active = active_r;
  assign status.kind   = d_r.kind;
  assign status.beat   = beat_r;

endmodule
`default_nettype wire

### src/lcd_draw_command_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_draw_command_engine
// Turns drawing commands into command, parameter and pixel-run bus words.
// ----------------------------------------------------------------------------
// A pixel, line or rectangle that survives clipping produces twelve output
// words (eleven when a clipped rectangle span wraps negative), a rotation two
// and an inversion one; the output sequencer moves one word per cycle
// unless out_stall holds it. Rejected draws and unused codes leave the output
// untouched. Commands are clipped and queued as they arrive, in a four-entry
// queue, so input taking continues while earlier commands are still being
// sent; input stalls only when that queue is full.
// ----------------------------------------------------------------------------
`include "lcd_draw_command_engine_assert.svh"

module lcd_draw_command_engine #(
  parameter int PANEL_WIDTH  = lcdd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdd_pkg::PANEL_HEIGHT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [2:0]                in_cmd,
  input  wire logic signed [15:0]        in_pos_x,
  input  wire logic signed [15:0]        in_pos_y,
  input  wire logic signed [15:0]        in_span_w,
  input  wire logic signed [15:0]        in_span_h,
  input  wire logic [15:0]               in_color,
  input  wire logic [1:0]                in_rotation,
  input  wire logic                      in_invert_on,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_is_command,
  output logic [15:0]                    out_bus_value,
  output logic [lcdd_pkg::RUN_W-1:0]     out_repeat_count,
  output logic                           out_last
);

  logic                 accept, push, pop;
  lcdd_pkg::desc_t      push_data, head;
  lcdd_pkg::q_status_t  q_st;
  lcdd_pkg::bk_status_t bk_st;

  assign in_stall = q_st.full;
  assign accept   = in_valid && !in_stall;

  lcdd_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd       (in_cmd),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .span_w    (in_span_w),
    .span_h    (in_span_h),
    .color     (in_color),
    .rotation  (in_rotation),
    .invert_on (in_invert_on),
    .push      (push),
    .push_data (push_data)
  );

  lcdd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_st)
  );

  lcdd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_status         (q_st),
    .pop              (pop),
    .status           (bk_st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_command   (out_is_command),
    .out_bus_value    (out_bus_value),
    .out_repeat_count (out_repeat_count),
    .out_last         (out_last)
  );

  `LCDD_ASSERT_SAME(a_cmd_single, out_valid && out_is_command, out_repeat_count == lcdd_pkg::RUN_W'(1), "command word with repeat count other than one")
  `LCDD_ASSERT_SAME(a_short_seq, bk_st.active && (bk_st.kind == lcdd_pkg::KIND_ROT || bk_st.kind == lcdd_pkg::KIND_INV), bk_st.beat == lcdd_pkg::BEAT_COLSET || bk_st.beat == lcdd_pkg::BEAT_X0_HI, "rotation or inversion sequence ran past its words")
  `LCDD_ASSERT_NEXT(a_rot_kept, accept && in_cmd == lcdd_pkg::CMD_ROTATE, !q_st.empty || bk_st.active, "accepted rotation word was dropped")

endmodule
`default_nettype wire
